// ===== design/bsu_pkg.sv =====
package bsu_pkg;

  localparam int STORE_DEPTH = 4096;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int LEN_W       = STORE_AW + 1;
  localparam int JRNL_DEPTH  = 256;
  localparam int JRNL_AW     = $clog2(JRNL_DEPTH);
  localparam int JCNT_W      = JRNL_AW + 1;
  localparam int PAT_DEPTH   = 16;
  localparam int PAT_AW      = $clog2(PAT_DEPTH);
  localparam int PLEN_W      = PAT_AW + 1;

  typedef logic [7:0]          byte_t;
  typedef logic [STORE_AW-1:0] addr_t;
  typedef logic [LEN_W-1:0]    len_t;
  typedef logic [JRNL_AW-1:0]  jaddr_t;
  typedef logic [JCNT_W-1:0]   jcnt_t;
  typedef logic [PAT_AW-1:0]   pidx_t;
  typedef logic [PLEN_W-1:0]   plen_t;

  // Request opcodes
  localparam logic [3:0] OP_CLEAR     = 4'd0;
  localparam logic [3:0] OP_APPEND    = 4'd1;
  localparam logic [3:0] OP_OVERWRITE = 4'd2;
  localparam logic [3:0] OP_UNDO      = 4'd3;
  localparam logic [3:0] OP_REVERT    = 4'd4;
  localparam logic [3:0] OP_CHANGED   = 4'd5;
  localparam logic [3:0] OP_PAT_CLEAR = 4'd6;
  localparam logic [3:0] OP_PAT_APP   = 4'd7;
  localparam logic [3:0] OP_FIND      = 4'd8;

  // Result status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_REFUSED   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [11:0] offset;
    logic [7:0]  value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] position;
    logic        changed;
  } rsp_t;

  typedef struct packed {
    addr_t offset;
    byte_t old_byte;
  } jrnl_ent_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    byte_t wdata;
    addr_t raddr;
  } store_cmd_t;

  typedef struct packed {
    logic      we;
    jaddr_t    waddr;
    jrnl_ent_t wdata;
    jaddr_t    raddr;
  } jrnl_cmd_t;

  typedef struct packed {
    logic  we;
    pidx_t waddr;
    byte_t wdata;
    pidx_t raddr;
  } pat_cmd_t;

endpackage

// ===== design/byte_store_with_undo_journal.sv =====
// Byte store with undo journal and pattern search. Issue a request by raising
// start_i while busy_o is low; the request is taken at that clock edge. Each
// request gives exactly one result on rsp_o, marked by done_o for a single
// cycle, and the receiver cannot stall it, so capture rsp_o whenever done_o is
// high. busy_o is low in the cycle done_o is shown, so the next request may
// be issued there. Clear, append, pattern clear/append, unused opcodes, a
// changed query outside the document and every request refused up front
// show done_o in the cycle after they are taken; overwrite, undo and a changed
// query inside the document first make one registered read of a store or the
// journal, then the write or compare. Revert is paced by the single read port
// of the original store feeding the current store. Find compares one byte at a
// time over the current store and pattern read ports, each byte taking a read
// state and then a compare state, and returns not found once no window fits.
// Stores come up with undefined contents and need no clearing pass after reset.
module byte_store_with_undo_journal (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  bsu_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output bsu_pkg::rsp_t rsp_o
);

  bsu_pkg::store_cmd_t cur_cmd;
  bsu_pkg::store_cmd_t org_cmd;
  bsu_pkg::jrnl_cmd_t  jrn_cmd;
  bsu_pkg::pat_cmd_t   pat_cmd;
  bsu_pkg::byte_t      cur_rdata;
  bsu_pkg::byte_t      org_rdata;
  bsu_pkg::jrnl_ent_t  jrn_rdata;
  bsu_pkg::byte_t      pat_rdata;

  // Sequencer with the address arithmetic and byte comparisons
  bsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cur_cmd_o   (cur_cmd),
    .cur_rdata_i (cur_rdata),
    .org_cmd_o   (org_cmd),
    .org_rdata_i (org_rdata),
    .jrn_cmd_o   (jrn_cmd),
    .jrn_rdata_i (jrn_rdata),
    .pat_cmd_o   (pat_cmd),
    .pat_rdata_i (pat_rdata)
  );

  // Current bytes: take edits
  bsu_ram #(
    .WIDTH (8),
    .DEPTH (bsu_pkg::STORE_DEPTH)
  ) u_cur_ram (
    .clk_i   (clk_i),
    .we_i    (cur_cmd.we),
    .waddr_i (cur_cmd.waddr),
    .wdata_i (cur_cmd.wdata),
    .raddr_i (cur_cmd.raddr),
    .rdata_o (cur_rdata)
  );

  // Original bytes: written only by append
  bsu_ram #(
    .WIDTH (8),
    .DEPTH (bsu_pkg::STORE_DEPTH)
  ) u_org_ram (
    .clk_i   (clk_i),
    .we_i    (org_cmd.we),
    .waddr_i (org_cmd.waddr),
    .wdata_i (org_cmd.wdata),
    .raddr_i (org_cmd.raddr),
    .rdata_o (org_rdata)
  );

  // Undo journal: offset and replaced byte per entry, used as a stack
  bsu_ram #(
    .WIDTH ($bits(bsu_pkg::jrnl_ent_t)),
    .DEPTH (bsu_pkg::JRNL_DEPTH)
  ) u_jrn_ram (
    .clk_i   (clk_i),
    .we_i    (jrn_cmd.we),
    .waddr_i (jrn_cmd.waddr),
    .wdata_i (jrn_cmd.wdata),
    .raddr_i (jrn_cmd.raddr),
    .rdata_o (jrn_rdata)
  );

  // Search pattern
  bsu_ram #(
    .WIDTH (8),
    .DEPTH (bsu_pkg::PAT_DEPTH)
  ) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_cmd.we),
    .waddr_i (pat_cmd.waddr),
    .wdata_i (pat_cmd.wdata),
    .raddr_i (pat_cmd.raddr),
    .rdata_o (pat_rdata)
  );

  // A result is only shown once the sequencer is back at rest
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_o)
    else $error("result strobe while sequencer busy");

  // An accepted request either completes at once or holds the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted request dropped");

  // A nonzero match position only comes with a successful find
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.position != '0) |-> (rsp_o.status == bsu_pkg::ST_DONE))
    else $error("match position with failing status");

  // A changed flag only comes with done status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.changed) |-> (rsp_o.status == bsu_pkg::ST_DONE))
    else $error("changed flag with failing status");

endmodule

// ===== design/bsu_ram.sv =====
module bsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/bsu_ctrl.sv =====
module bsu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  bsu_pkg::req_t       req_i,
  output logic                busy_o,
  output logic                done_o,
  output bsu_pkg::rsp_t       rsp_o,
  output bsu_pkg::store_cmd_t cur_cmd_o,
  input  bsu_pkg::byte_t      cur_rdata_i,
  output bsu_pkg::store_cmd_t org_cmd_o,
  input  bsu_pkg::byte_t      org_rdata_i,
  output bsu_pkg::jrnl_cmd_t  jrn_cmd_o,
  input  bsu_pkg::jrnl_ent_t  jrn_rdata_i,
  output bsu_pkg::pat_cmd_t   pat_cmd_o,
  input  bsu_pkg::byte_t      pat_rdata_i
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_OVW_CHK  = 3'd1;
  localparam logic [2:0] S_UNDO_WR  = 3'd2;
  localparam logic [2:0] S_CHG_CMP  = 3'd3;
  localparam logic [2:0] S_REVERT   = 3'd4;
  localparam logic [2:0] S_FIND_RD  = 3'd5;
  localparam logic [2:0] S_FIND_CMP = 3'd6;
  localparam logic [2:0] S_SPARE    = 3'd7;

  logic [2:0]          state_q, state_d;
  bsu_pkg::len_t       len_q, len_d;
  bsu_pkg::jcnt_t      jc_q, jc_d;
  bsu_pkg::plen_t      plen_q, plen_d;
  logic                done_q, done_d;
  logic                pend_q, pend_d;
  bsu_pkg::rsp_t       rsp_q, rsp_d;
  bsu_pkg::req_t       req_q, req_d;
  bsu_pkg::len_t       pos_q, pos_d;
  bsu_pkg::pidx_t      k_q, k_d;
  bsu_pkg::len_t       idx_q, idx_d;
  bsu_pkg::addr_t      paddr_q, paddr_d;
  bsu_pkg::jcnt_t      jc_dec;
  bsu_pkg::len_t       win_end;
  logic                accept;

  assign accept  = start_i && (state_q == S_IDLE);
  assign jc_dec  = jc_q - 1'b1;
  // adder: end of the candidate window
  assign win_end = pos_q + bsu_pkg::len_t'(plen_q);

  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    jc_d      = jc_q;
    plen_d    = plen_q;
    done_d    = 1'b0;
    pend_d    = 1'b0;
    rsp_d     = rsp_q;
    req_d     = req_q;
    pos_d     = pos_q;
    k_d       = k_q;
    idx_d     = idx_q;
    paddr_d   = paddr_q;
    cur_cmd_o = '0;
    org_cmd_o = '0;
    jrn_cmd_o = '0;
    pat_cmd_o = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d  = req_i;
          done_d = 1'b1;
          rsp_d  = '0;
          case (req_i.opcode)
            bsu_pkg::OP_CLEAR: begin
              len_d = '0;
              jc_d  = '0;
            end
            bsu_pkg::OP_APPEND: begin
              if (len_q == bsu_pkg::len_t'(bsu_pkg::STORE_DEPTH)) begin
                rsp_d.status = bsu_pkg::ST_FULL;
              end else begin
                cur_cmd_o.we    = 1'b1;
                cur_cmd_o.waddr = len_q[bsu_pkg::STORE_AW-1:0];
                cur_cmd_o.wdata = req_i.value;
                org_cmd_o.we    = 1'b1;
                org_cmd_o.waddr = len_q[bsu_pkg::STORE_AW-1:0];
                org_cmd_o.wdata = req_i.value;
                len_d           = len_q + 1'b1;
              end
            end
            bsu_pkg::OP_OVERWRITE: begin
              if (bsu_pkg::len_t'(req_i.offset) >= len_q) begin
                rsp_d.status = bsu_pkg::ST_REFUSED;
              end else begin
                cur_cmd_o.raddr = req_i.offset;
                done_d          = 1'b0;
                state_d         = S_OVW_CHK;
              end
            end
            bsu_pkg::OP_UNDO: begin
              if (jc_q == '0) begin
                rsp_d.status = bsu_pkg::ST_REFUSED;
              end else begin
                jrn_cmd_o.raddr = jc_dec[bsu_pkg::JRNL_AW-1:0];
                done_d          = 1'b0;
                state_d         = S_UNDO_WR;
              end
            end
            bsu_pkg::OP_REVERT: begin
              jc_d    = '0;
              idx_d   = '0;
              done_d  = 1'b0;
              state_d = S_REVERT;
            end
            bsu_pkg::OP_CHANGED: begin
              if (bsu_pkg::len_t'(req_i.offset) < len_q) begin
                cur_cmd_o.raddr = req_i.offset;
                org_cmd_o.raddr = req_i.offset;
                done_d          = 1'b0;
                state_d         = S_CHG_CMP;
              end
            end
            bsu_pkg::OP_PAT_CLEAR: begin
              plen_d = '0;
            end
            bsu_pkg::OP_PAT_APP: begin
              if (plen_q == bsu_pkg::plen_t'(bsu_pkg::PAT_DEPTH)) begin
                rsp_d.status = bsu_pkg::ST_FULL;
              end else begin
                pat_cmd_o.we    = 1'b1;
                pat_cmd_o.waddr = plen_q[bsu_pkg::PAT_AW-1:0];
                pat_cmd_o.wdata = req_i.value;
                plen_d          = plen_q + 1'b1;
              end
            end
            bsu_pkg::OP_FIND: begin
              if (plen_q == '0 || bsu_pkg::len_t'(req_i.offset) >= len_q ||
                  bsu_pkg::len_t'(plen_q) > len_q) begin
                rsp_d.status = bsu_pkg::ST_NOT_FOUND;
              end else begin
                pos_d   = bsu_pkg::len_t'(req_i.offset);
                k_d     = '0;
                done_d  = 1'b0;
                state_d = S_FIND_RD;
              end
            end
            default: begin
              rsp_d.status = bsu_pkg::ST_REFUSED;
            end
          endcase
        end
      end
      S_OVW_CHK: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (cur_rdata_i == req_q.value) begin
          rsp_d.status = bsu_pkg::ST_REFUSED;
        end else if (jc_q == bsu_pkg::jcnt_t'(bsu_pkg::JRNL_DEPTH)) begin
          rsp_d.status = bsu_pkg::ST_FULL;
        end else begin
          jrn_cmd_o.we             = 1'b1;
          jrn_cmd_o.waddr          = jc_q[bsu_pkg::JRNL_AW-1:0];
          jrn_cmd_o.wdata.offset   = req_q.offset;
          jrn_cmd_o.wdata.old_byte = cur_rdata_i;
          jc_d                     = jc_q + 1'b1;
          cur_cmd_o.we             = 1'b1;
          cur_cmd_o.waddr          = req_q.offset;
          cur_cmd_o.wdata          = req_q.value;
        end
      end
      S_UNDO_WR: begin
        cur_cmd_o.we    = 1'b1;
        cur_cmd_o.waddr = jrn_rdata_i.offset;
        cur_cmd_o.wdata = jrn_rdata_i.old_byte;
        jc_d            = jc_dec;
        done_d          = 1'b1;
        state_d         = S_IDLE;
      end
      S_CHG_CMP: begin
        rsp_d.changed = (cur_rdata_i != org_rdata_i);
        done_d        = 1'b1;
        state_d       = S_IDLE;
      end
      S_REVERT: begin
        // read one original byte a cycle, write it to current in the cycle after
        if (idx_q < len_q) begin
          org_cmd_o.raddr = idx_q[bsu_pkg::STORE_AW-1:0];
          idx_d           = idx_q + 1'b1;
          pend_d          = 1'b1;
          paddr_d         = idx_q[bsu_pkg::STORE_AW-1:0];
        end else if (!pend_q) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
        if (pend_q) begin
          cur_cmd_o.we    = 1'b1;
          cur_cmd_o.waddr = paddr_q;
          cur_cmd_o.wdata = org_rdata_i;
        end
      end
      S_FIND_RD: begin
        if (win_end > len_q) begin
          rsp_d.status = bsu_pkg::ST_NOT_FOUND;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cur_cmd_o.raddr = pos_q[bsu_pkg::STORE_AW-1:0] + bsu_pkg::addr_t'(k_q);
          pat_cmd_o.raddr = k_q;
          state_d         = S_FIND_CMP;
        end
      end
      S_FIND_CMP: begin
        state_d = S_FIND_RD;
        if (cur_rdata_i != pat_rdata_i) begin
          pos_d = pos_q + 1'b1;
          k_d   = '0;
        end else if (bsu_pkg::plen_t'(k_q) + 1'b1 == plen_q) begin
          rsp_d.position = pos_q[bsu_pkg::STORE_AW-1:0];
          done_d         = 1'b1;
          state_d        = S_IDLE;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_SPARE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      jc_q    <= '0;
      plen_q  <= '0;
      done_q  <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      jc_q    <= jc_d;
      plen_q  <= plen_d;
      done_q  <= done_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q   <= rsp_d;
    req_q   <= req_d;
    pos_q   <= pos_d;
    k_q     <= k_d;
    idx_q   <= idx_d;
    paddr_q <= paddr_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== sim/byte_store_with_undo_journal_tb.sv =====
module byte_store_with_undo_journal_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bsu_pkg::*;

  // Opcodes the block does not define; they must come back refused.
  localparam logic [3:0] OP_FIRST_UNUSED = 4'd9;
  localparam logic [3:0] OP_LAST_UNUSED  = 4'd15;

  localparam rsp_t RSP_DONE    = '{ST_DONE, 12'd0, 1'b0};
  localparam rsp_t RSP_REFUSED = '{ST_REFUSED, 12'd0, 1'b0};
  localparam rsp_t RSP_MISS    = '{ST_NOT_FOUND, 12'd0, 1'b0};

  localparam int RANDOM_REQS = 870;   // random requests, split around the deep phase
  localparam int DOC_CAP     = 48;    // keep random documents short so find and revert stay fast
  localparam int DEEP_LEN    = 64;    // document length used while the journal is filled
  localparam int DRAIN_LIMIT = 400000;
  localparam int DIR_ROWS    = 27;

  typedef struct {
    req_t req;
    bit   typed;  // want holds a hand-written response
    rsp_t want;
  } dir_row_t;

  logic clk    = 1'b0;
  logic rst_n  = 1'b0;
  logic start  = 1'b0;
  req_t req    = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  // Shadow of the document, journal and pattern, updated as each request is taken.
  byte_t cur_mem  [STORE_DEPTH];
  byte_t orig_mem [STORE_DEPTH];
  addr_t jrnl_addr[JRNL_DEPTH];
  byte_t jrnl_old [JRNL_DEPTH];
  byte_t pat_mem  [PAT_DEPTH];
  len_t  doc_len  = '0;
  jcnt_t jrnl_cnt = '0;
  plen_t pat_len  = '0;

  rsp_t     awaited_rsp[$];  // responses owed by the block, oldest first
  req_t     pat_script[$];   // pattern load sequence still to be issued
  dir_row_t dir_rows[DIR_ROWS];
  int       mismatch_cnt = 0;
  int       rsp_cnt      = 0;
  int       burst_left   = 0;

  byte_store_with_undo_journal dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .start_i(start),
    .req_i  (req),
    .busy_o (busy),
    .done_o (done),
    .rsp_o  (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    mismatch_cnt++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  function automatic req_t mk_req(logic [3:0] op, logic [11:0] off, logic [7:0] val);
    req_t r;
    r.opcode = op;
    r.offset = off;
    r.value  = val;
    return r;
  endfunction

  // Apply one request to the shadow state and return the response it owes.
  function automatic rsp_t doc_response(req_t r);
    rsp_t rsp_w;
    int   pos;
    int   k;
    bit   hit;
    bit   found;
    rsp_w = '0;
    case (r.opcode)
      OP_CLEAR: begin
        doc_len  = '0;
        jrnl_cnt = '0;
      end
      OP_APPEND: begin
        if (doc_len >= STORE_DEPTH) begin
          rsp_w.status = ST_FULL;
        end else begin
          cur_mem[doc_len[STORE_AW-1:0]]  = r.value;
          orig_mem[doc_len[STORE_AW-1:0]] = r.value;
          doc_len++;
        end
      end
      OP_OVERWRITE: begin
        if (r.offset >= doc_len || cur_mem[r.offset] == r.value) begin
          rsp_w.status = ST_REFUSED;
        end else if (jrnl_cnt >= JRNL_DEPTH) begin
          rsp_w.status = ST_FULL;
        end else begin
          jrnl_addr[jrnl_cnt[JRNL_AW-1:0]] = r.offset;
          jrnl_old[jrnl_cnt[JRNL_AW-1:0]]  = cur_mem[r.offset];
          jrnl_cnt++;
          cur_mem[r.offset] = r.value;
        end
      end
      OP_UNDO: begin
        if (jrnl_cnt == 0) begin
          rsp_w.status = ST_REFUSED;
        end else begin
          jrnl_cnt--;
          cur_mem[jrnl_addr[jrnl_cnt[JRNL_AW-1:0]]] = jrnl_old[jrnl_cnt[JRNL_AW-1:0]];
        end
      end
      OP_REVERT: begin
        for (pos = 0; pos < doc_len; pos++) cur_mem[addr_t'(pos)] = orig_mem[addr_t'(pos)];
        jrnl_cnt = '0;
      end
      OP_CHANGED: begin
        if (r.offset < doc_len && cur_mem[r.offset] != orig_mem[r.offset])
          rsp_w.changed = 1'b1;
      end
      OP_PAT_CLEAR: pat_len = '0;
      OP_PAT_APP: begin
        if (pat_len >= PAT_DEPTH) begin
          rsp_w.status = ST_FULL;
        end else begin
          pat_mem[pat_len[PAT_AW-1:0]] = r.value;
          pat_len++;
        end
      end
      OP_FIND: begin
        rsp_w.status = ST_NOT_FOUND;
        found = 1'b0;
        if (pat_len != 0 && r.offset < doc_len && pat_len <= doc_len) begin
          pos = int'(r.offset);
          while (!found && pos + pat_len <= doc_len) begin
            hit = 1'b1;
            for (k = 0; k < pat_len; k++)
              if (cur_mem[addr_t'(pos + k)] != pat_mem[pidx_t'(k)]) hit = 1'b0;
            if (hit) begin
              found          = 1'b1;
              rsp_w.status   = ST_DONE;
              rsp_w.position = pos[11:0];
            end
            pos++;
          end
        end
      end
      default: rsp_w.status = ST_REFUSED;
    endcase
    return rsp_w;
  endfunction

  // Draw the pause before the next request; now and then run a burst with none.
  function automatic int idle_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(10, 40);
    return $urandom_range(0, 9);
  endfunction

  // Issue one request and hold it until the block takes it. The response is
  // predicted at the taking edge, so the shadow state follows request order.
  task automatic send_request(input req_t r, input bit typed, input rsp_t want);
    int   gap;
    rsp_t predicted;
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = doc_response(r);
    awaited_rsp = {awaited_rsp, (typed ? want : predicted)};
  endtask

  task automatic send_plain(input req_t r);
    send_request(r, 1'b0, RSP_DONE);
  endtask

  // Queue a pattern load: usually a short slice of the current document so
  // finds hit, sometimes random bytes, and now and then enough to overflow.
  task automatic plan_pattern_load();
    int n;
    int at;
    int k;
    pat_script = {pat_script, mk_req(OP_PAT_CLEAR, 12'($urandom), 8'($urandom))};
    if ($urandom_range(0, 9) == 0) begin
      n = PAT_DEPTH + 1 + $urandom_range(0, 2);
      for (k = 0; k < n; k++)
        pat_script = {pat_script, mk_req(OP_PAT_APP, 12'($urandom), 8'($urandom))};
    end else begin
      n  = $urandom_range(1, 4);
      at = (doc_len > n) ? $urandom_range(0, doc_len - n) : 0;
      for (k = 0; k < n; k++)
        pat_script = {pat_script, mk_req(OP_PAT_APP, 12'($urandom),
                                         (at + k < doc_len && $urandom_range(0, 7) != 0) ?
                                         cur_mem[addr_t'(at + k)] : 8'($urandom))};
    end
  endtask

  task automatic next_random_req(output req_t r);
    int roll;
    if (pat_script.size() == 0) begin
      r    = mk_req(OP_CLEAR, 12'($urandom), 8'($urandom));
      roll = $urandom_range(0, 99);
      if (roll < 3)       r.opcode = OP_CLEAR;
      else if (roll < 25) r.opcode = (doc_len < DOC_CAP) ? OP_APPEND : OP_OVERWRITE;
      else if (roll < 45) r.opcode = OP_OVERWRITE;
      else if (roll < 55) r.opcode = OP_UNDO;
      else if (roll < 59) r.opcode = OP_REVERT;
      else if (roll < 69) r.opcode = OP_CHANGED;
      else if (roll < 77) plan_pattern_load();
      else if (roll < 91) r.opcode = OP_FIND;
      else if (roll < 94) r.opcode = OP_PAT_APP;
      else if (roll < 97) r.opcode = 4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
      else                r.opcode = OP_PAT_CLEAR;
      // Aim most positions inside the document; leave the rest anywhere.
      if (doc_len != 0 && r.opcode inside {OP_OVERWRITE, OP_CHANGED, OP_FIND} &&
          $urandom_range(0, 4) != 0)
        r.offset = 12'($urandom_range(0, doc_len - 1));
      if (r.opcode == OP_FIND && $urandom_range(0, 2) == 0) r.offset = '0;
      // Rewrite a byte with its own value now and then.
      if (r.opcode == OP_OVERWRITE && r.offset < doc_len && $urandom_range(0, 4) == 0)
        r.value = cur_mem[r.offset];
    end
    if (pat_script.size() != 0) r = pat_script.pop_front();
  endtask

  task automatic random_phase(input int reqs);
    int   taken;
    req_t r;
    taken = 0;
    while (taken < reqs) begin
      next_random_req(r);
      send_plain(r);
      // Unused opcodes are noise; count only real requests.
      if (r.opcode <= OP_FIND) taken++;
    end
  endtask

  // Fill and drain the journal over a fixed document and search it, which
  // reaches the journal full status.
  task automatic deep_phase();
    int   i;
    int   at;
    addr_t probe;
    send_plain(mk_req(OP_CLEAR, '0, '0));
    for (i = 0; i < DEEP_LEN; i++)
      send_plain(mk_req(OP_APPEND, 12'($urandom), 8'($urandom)));
    send_plain(mk_req(OP_PAT_CLEAR, '0, '0));
    for (i = 0; i < 4; i++)
      send_plain(mk_req(OP_PAT_APP, '0, cur_mem[addr_t'(DEEP_LEN - 8 + i)]));
    send_plain(mk_req(OP_FIND, 12'($urandom_range(0, DEEP_LEN - 9)), '0));
    send_plain(mk_req(OP_FIND, 12'hfff, '0));
    for (i = 0; i < JRNL_DEPTH + 4; i++) begin
      at = $urandom_range(0, DEEP_LEN - 1);
      send_plain(mk_req(OP_OVERWRITE, 12'(at),
                        cur_mem[addr_t'(at)] ^ 8'($urandom_range(1, 255))));
    end
    send_plain(mk_req(OP_CHANGED, 12'hfff, '0));
    for (i = 0; i <= JRNL_DEPTH; i++) send_plain(mk_req(OP_UNDO, 12'($urandom), 8'($urandom)));
    for (i = 0; i < 20; i++) begin
      at = $urandom_range(0, DEEP_LEN - 1);
      send_plain(mk_req(OP_OVERWRITE, 12'(at),
                        cur_mem[addr_t'(at)] ^ 8'($urandom_range(1, 255))));
    end
    probe = jrnl_addr[0];
    send_plain(mk_req(OP_CHANGED, probe, '0));
    send_plain(mk_req(OP_REVERT, '0, '0));
    send_plain(mk_req(OP_CHANGED, probe, '0));
    send_plain(mk_req(OP_PAT_CLEAR, '0, '0));
    for (i = 0; i < PAT_DEPTH; i++)
      send_plain(mk_req(OP_PAT_APP, '0, cur_mem[addr_t'(DEEP_LEN - PAT_DEPTH + i)]));
    send_plain(mk_req(OP_FIND, '0, '0));
    send_plain(mk_req(OP_CLEAR, '0, '0));
  endtask

  // Take every done strobe at the edge that ends it and check it against the
  // oldest owed response, field by field.
  always @(posedge clk) begin : watch_rsp
    rsp_t want;
    if (rst_n && done) begin
      rsp_cnt++;
      if (awaited_rsp.size() == 0) begin
        flag_mismatch($sformatf("response %0d arrived with no request owed", rsp_cnt));
      end else begin
        want = awaited_rsp.pop_front();
        if (rsp.status !== want.status)
          flag_mismatch($sformatf("response %0d: status %0d, expected %0d",
                                  rsp_cnt, rsp.status, want.status));
        if (rsp.position !== want.position)
          flag_mismatch($sformatf("response %0d: position %0d, expected %0d",
                                  rsp_cnt, rsp.position, want.position));
        if (rsp.changed !== want.changed)
          flag_mismatch($sformatf("response %0d: changed %0b, expected %0b",
                                  rsp_cnt, rsp.changed, want.changed));
      end
    end
  end

  initial begin
    int i;
    int waited;
    // Directed opening: empty-document refusals, extremes of the fields,
    // same-byte overwrite, find that does not fit, undo after revert.
    dir_rows = '{
      '{'{OP_UNDO,         12'h000, 8'h00}, 1'b1, RSP_REFUSED},
      '{'{OP_FIND,         12'h000, 8'h00}, 1'b1, RSP_MISS},
      '{'{OP_OVERWRITE,    12'h000, 8'hff}, 1'b1, RSP_REFUSED},
      '{'{OP_CHANGED,      12'hfff, 8'hff}, 1'b1, RSP_DONE},
      '{'{OP_LAST_UNUSED,  12'hfff, 8'hff}, 1'b1, RSP_REFUSED},
      '{'{OP_APPEND,       12'h000, 8'h00}, 1'b1, RSP_DONE},
      '{'{OP_APPEND,       12'hfff, 8'hff}, 1'b1, RSP_DONE},
      '{'{OP_APPEND,       12'h000, 8'h5a}, 1'b0, RSP_DONE},
      '{'{OP_APPEND,       12'h000, 8'ha5}, 1'b0, RSP_DONE},
      '{'{OP_OVERWRITE,    12'h001, 8'hff}, 1'b1, RSP_REFUSED},
      '{'{OP_OVERWRITE,    12'h001, 8'h00}, 1'b0, RSP_DONE},
      '{'{OP_CHANGED,      12'h001, 8'h00}, 1'b0, RSP_DONE},
      '{'{OP_CHANGED,      12'h000, 8'h00}, 1'b0, RSP_DONE},
      '{'{OP_OVERWRITE,    12'hfff, 8'h00}, 1'b1, RSP_REFUSED},
      '{'{OP_PAT_APP,      12'h000, 8'h5a}, 1'b0, RSP_DONE},
      '{'{OP_PAT_APP,      12'h000, 8'ha5}, 1'b0, RSP_DONE},
      '{'{OP_FIND,         12'h000, 8'h00}, 1'b0, RSP_DONE},
      '{'{OP_FIND,         12'h003, 8'h00}, 1'b1, RSP_MISS},
      '{'{OP_FIND,         12'hfff, 8'h00}, 1'b1, RSP_MISS},
      '{'{OP_OVERWRITE,    12'h003, 8'h00}, 1'b0, RSP_DONE},
      '{'{OP_UNDO,         12'h000, 8'h00}, 1'b0, RSP_DONE},
      '{'{OP_OVERWRITE,    12'h000, 8'hff}, 1'b0, RSP_DONE},
      '{'{OP_REVERT,       12'h000, 8'h00}, 1'b0, RSP_DONE},
      '{'{OP_UNDO,         12'h000, 8'h00}, 1'b1, RSP_REFUSED},
      '{'{OP_CLEAR,        12'h000, 8'h00}, 1'b1, RSP_DONE},
      '{'{OP_PAT_CLEAR,    12'h000, 8'h00}, 1'b1, RSP_DONE},
      '{'{OP_FIRST_UNUSED, 12'h000, 8'h00}, 1'b1, RSP_REFUSED}
    };

    // Hold reset at the start, then release it on an edge.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_ROWS; i++)
      send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

    random_phase(RANDOM_REQS / 2);
    deep_phase();
    random_phase(RANDOM_REQS - RANDOM_REQS / 2);
    start <= 1'b0;

    // Drain: wait for every owed response, bounded by the slowest find.
    waited = 0;
    while (awaited_rsp.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (awaited_rsp.size() != 0)
      flag_mismatch($sformatf("%0d responses never arrived", awaited_rsp.size()));
    // Leave room for a stray strobe to show up.
    repeat (20) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #50_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== byte_store_with_undo_journal.f =====
design/bsu_pkg.sv
design/bsu_ram.sv
design/bsu_ctrl.sv
design/byte_store_with_undo_journal.sv
sim/byte_store_with_undo_journal_tb.sv
